// File: hdl/bpmc_pkg.sv
// Package for the battery pack power mode controller.
// Holds mode, LED and beep codes, register indexes, reset values and the shared structs.
// No dependencies.
package bpmc_pkg;

  // Default width of the mode and gauge age counters.
  localparam int TICK_BITS_DEF = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_DATA_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_LOCKOUT_TIME   = 3'd2;
  localparam logic [2:0] REG_CHARGER_VOLT   = 3'd3;
  localparam logic [2:0] REG_CURRENT_OFF    = 3'd4;
  localparam logic [2:0] REG_CURRENT_START  = 3'd5;
  localparam logic [2:0] REG_LOW_CURRENT_T  = 3'd6;
  localparam logic [2:0] REG_FINISH_TIME    = 3'd7;

  // Register reset values.
  localparam logic [23:0]        RST_DATA_TIMEOUT  = 24'd1000;
  localparam logic [23:0]        RST_IDLE_TIMEOUT  = 24'd60000;
  localparam logic [23:0]        RST_LOCKOUT_TIME  = 24'd1000;
  localparam logic [15:0]        RST_CHARGER_VOLT  = 16'd20000;
  localparam logic signed [15:0] RST_CURRENT_OFF   = 16'sd100;
  localparam logic signed [15:0] RST_CURRENT_START = 16'sd300;
  localparam logic [23:0]        RST_LOW_CURRENT_T = 24'd5000;
  localparam logic [23:0]        RST_FINISH_TIME   = 24'd60000;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_NOBAT = 4'd1,
    MODE_FSIL  = 4'd2,
    MODE_FAULT = 4'd3,
    MODE_OUT   = 4'd4,
    MODE_LOCK  = 4'd5,
    MODE_CHG   = 4'd6,
    MODE_PRES  = 4'd7,
    MODE_FIN   = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    LED_OFF          = 3'd0,
    LED_RED_FAST     = 3'd1,
    LED_GREEN_FADE   = 3'd2,
    LED_ORANGE_FAST  = 3'd3,
    LED_ORANGE_BLINK = 3'd4,
    LED_GREEN_BLINK  = 3'd5,
    LED_RED_BLINK    = 3'd6
  } led_t;

  typedef enum logic [2:0] {
    BEEP_NONE   = 3'd0,
    BEEP_ONCE   = 3'd1,
    BEEP_TWICE  = 3'd2,
    BEEP_THRICE = 3'd3,
    BEEP_FAULT  = 3'd4
  } beep_t;

  typedef struct packed {
    logic [23:0]        data_timeout;
    logic [23:0]        idle_timeout;
    logic [23:0]        lockout_time;
    logic [15:0]        charger_voltage_threshold;
    logic signed [15:0] current_off_threshold;
    logic signed [15:0] current_start_threshold;
    logic [23:0]        low_current_time;
    logic [23:0]        finish_time;
  } cfg_t;

  typedef struct packed {
    logic               polarity_good;
    logic [15:0]        external_voltage;
    logic               pack_present;
    logic               button_on;
    logic               host_message_seen;
    logic               gauge_fresh;
    logic signed [15:0] gauge_current;
    logic               gauge_full;
  } item_t;

  // Mode and latched gauge state that does not depend on the counter width.
  typedef struct packed {
    mode_t              mode;
    logic signed [15:0] held_current;
    logic               held_full;
    logic               fault_seen;
  } ctl_state_t;

  typedef struct packed {
    mode_t mode;
    logic  discharge_enable;
    logic  charge_enable;
    led_t  led_pattern;
    beep_t beep_request;
    logic  sleep_request;
    logic  fault_recorded;
  } result_t;

  // LED pattern shown in each mode.
  function automatic led_t led_of_mode(input mode_t m);
    led_t l;
    case (m)
      MODE_NOBAT: l = LED_RED_BLINK;
      MODE_FAULT: l = LED_RED_FAST;
      MODE_OUT:   l = LED_GREEN_FADE;
      MODE_LOCK:  l = LED_ORANGE_FAST;
      MODE_CHG:   l = LED_ORANGE_FAST;
      MODE_PRES:  l = LED_ORANGE_BLINK;
      MODE_FIN:   l = LED_GREEN_BLINK;
      default:    l = LED_OFF;
    endcase
    return l;
  endfunction

  // The charge path is on while output is on and in every charge mode past lockout.
  function automatic logic chg_of_mode(input mode_t m);
    return (m == MODE_OUT) || (m == MODE_CHG) || (m == MODE_PRES) || (m == MODE_FIN);
  endfunction

endpackage

// File: hdl/bpmc_step.sv
// Next-state and result logic for one millisecond tick of the power mode controller.
// Purely combinational; uses bpmc_pkg types and tables.
module bpmc_step #(
  parameter int TICK_BITS = bpmc_pkg::TICK_BITS_DEF
) (
  input  bpmc_pkg::item_t      item,
  input  bpmc_pkg::cfg_t       cfg,
  input  bpmc_pkg::ctl_state_t st,
  input  logic [TICK_BITS-1:0] mode_ticks,
  input  logic [TICK_BITS-1:0] gauge_age,
  output bpmc_pkg::ctl_state_t st_nxt,
  output logic [TICK_BITS-1:0] mode_ticks_nxt,
  output logic [TICK_BITS-1:0] gauge_age_nxt,
  output bpmc_pkg::result_t    res
);

  // Width at which counters are compared against the 24-bit limits.
  localparam int CW = (TICK_BITS > 24) ? TICK_BITS : 24;

  // Saturating increment.
  function automatic logic [TICK_BITS-1:0] bump(input logic [TICK_BITS-1:0] c);
    return (&c) ? c : c + TICK_BITS'(1);
  endfunction

  bpmc_pkg::mode_t      mode0;
  logic [TICK_BITS-1:0] mt0;
  logic [TICK_BITS-1:0] mt_b;
  logic [TICK_BITS-1:0] age_b;
  logic signed [15:0]   cur_h;
  logic                 full_h;
  logic                 low;
  logic                 sleep;
  bpmc_pkg::beep_t      beep;
  bpmc_pkg::mode_t      mode_n;
  logic                 fault_n;

  always_comb begin
    // A missing pack forces no-battery mode ahead of the mode logic.
    if (!item.pack_present && st.mode != bpmc_pkg::MODE_NOBAT) begin
      mode0 = bpmc_pkg::MODE_NOBAT;
      mt0   = '0;
    end else begin
      mode0 = st.mode;
      mt0   = mode_ticks;
    end

    // Gauge latch: fresh data restarts the age, stale data clears after the timeout.
    age_b = bump(gauge_age);
    if (item.gauge_fresh) begin
      cur_h         = item.gauge_current;
      full_h        = item.gauge_full;
      gauge_age_nxt = '0;
    end else if (CW'(age_b) > CW'(cfg.data_timeout)) begin
      cur_h         = '0;
      full_h        = 1'b0;
      gauge_age_nxt = '0;
    end else begin
      cur_h         = st.held_current;
      full_h        = st.held_full;
      gauge_age_nxt = age_b;
    end

    beep           = bpmc_pkg::BEEP_NONE;
    sleep          = 1'b0;
    fault_n        = st.fault_seen;
    mode_n         = mode0;
    mode_ticks_nxt = mt0;
    mt_b           = bump(mt0);
    low            = 1'b0;

    // Mode transitions; at most one per tick.
    case (mode0)
      bpmc_pkg::MODE_IDLE: begin
        if (item.host_message_seen) mt_b = '0;
        mode_ticks_nxt = mt_b;
        if (!item.polarity_good) begin
          fault_n = 1'b1;
          mode_n  = bpmc_pkg::MODE_FSIL;
        end else if (item.button_on) begin
          mode_n = bpmc_pkg::MODE_OUT;
          beep   = bpmc_pkg::BEEP_TWICE;
        end else if (item.external_voltage > cfg.charger_voltage_threshold) begin
          mode_n         = bpmc_pkg::MODE_LOCK;
          mode_ticks_nxt = '0;
          beep           = bpmc_pkg::BEEP_TWICE;
        end else if (CW'(mt_b) == CW'(cfg.idle_timeout)) begin
          // Silent restart of the idle count with a sleep pulse.
          sleep          = 1'b1;
          mode_ticks_nxt = '0;
        end
      end
      bpmc_pkg::MODE_NOBAT: begin
        if (item.pack_present) begin
          mode_n         = bpmc_pkg::MODE_IDLE;
          mode_ticks_nxt = '0;
          beep           = bpmc_pkg::BEEP_ONCE;
        end
      end
      bpmc_pkg::MODE_FSIL: begin
        if (item.button_on) mode_n = bpmc_pkg::MODE_FAULT;
      end
      bpmc_pkg::MODE_FAULT: begin
        beep = bpmc_pkg::BEEP_FAULT;
        if (!item.button_on) mode_n = bpmc_pkg::MODE_FSIL;
      end
      bpmc_pkg::MODE_OUT: begin
        if (!item.button_on) begin
          mode_n         = bpmc_pkg::MODE_IDLE;
          mode_ticks_nxt = '0;
          beep           = bpmc_pkg::BEEP_ONCE;
        end
      end
      bpmc_pkg::MODE_LOCK: begin
        mode_ticks_nxt = mt_b;
        if (CW'(mt_b) > CW'(cfg.lockout_time)) begin
          mode_n         = bpmc_pkg::MODE_CHG;
          mode_ticks_nxt = '0;
        end
      end
      bpmc_pkg::MODE_CHG: begin
        low            = (cur_h < cfg.current_off_threshold) || full_h;
        mode_ticks_nxt = low ? mt_b : '0;
        if (item.button_on) begin
          mode_n = bpmc_pkg::MODE_OUT;
          beep   = bpmc_pkg::BEEP_TWICE;
        end else if (item.external_voltage < cfg.charger_voltage_threshold) begin
          mode_n         = bpmc_pkg::MODE_IDLE;
          mode_ticks_nxt = '0;
          beep           = bpmc_pkg::BEEP_ONCE;
        end else if (CW'(mode_ticks_nxt) >= CW'(cfg.low_current_time)) begin
          mode_ticks_nxt = '0;
          if (full_h) begin
            mode_n = bpmc_pkg::MODE_FIN;
            beep   = bpmc_pkg::BEEP_THRICE;
          end else begin
            mode_n = bpmc_pkg::MODE_PRES;
          end
        end
      end
      bpmc_pkg::MODE_PRES, bpmc_pkg::MODE_FIN: begin
        low            = cur_h < cfg.current_off_threshold;
        mode_ticks_nxt = low ? mt_b : '0;
        if (item.button_on) begin
          mode_n = bpmc_pkg::MODE_OUT;
          beep   = bpmc_pkg::BEEP_TWICE;
        end else if (item.external_voltage < cfg.charger_voltage_threshold) begin
          mode_n         = bpmc_pkg::MODE_IDLE;
          mode_ticks_nxt = '0;
          beep           = bpmc_pkg::BEEP_ONCE;
        end else if (cur_h >= cfg.current_start_threshold) begin
          mode_n         = bpmc_pkg::MODE_CHG;
          mode_ticks_nxt = '0;
        end else if (CW'(mode_ticks_nxt) >= CW'(cfg.finish_time)) begin
          mode_n         = bpmc_pkg::MODE_IDLE;
          mode_ticks_nxt = '0;
          beep           = bpmc_pkg::BEEP_ONCE;
        end
      end
      default: begin
        mode_n         = bpmc_pkg::MODE_IDLE;
        mode_ticks_nxt = '0;
        beep           = bpmc_pkg::BEEP_ONCE;
      end
    endcase

    st_nxt.mode         = mode_n;
    st_nxt.held_current = cur_h;
    st_nxt.held_full    = full_h;
    st_nxt.fault_seen   = fault_n;

    // Result fields follow the mode after the tick.
    res.mode             = mode_n;
    res.discharge_enable = (mode_n == bpmc_pkg::MODE_OUT);
    res.charge_enable    = bpmc_pkg::chg_of_mode(mode_n);
    res.led_pattern      = bpmc_pkg::led_of_mode(mode_n);
    res.beep_request     = beep;
    res.sleep_request    = sleep;
    res.fault_recorded   = fault_n;
  end

endmodule

// File: hdl/battery_pack_power_mode_controller_core.sv
// Top level of the battery pack power mode controller: input register, tick logic, result register.
// Depends on bpmc_pkg and bpmc_step.
//
//  channel   direction  handshake                  payload
//  in_*      input      in_valid / in_stall        one millisecond tick with its readings
//  out_*     output     out_valid / out_stall      mode, enables, LED, beep, sleep, fault
//  cfg_*     input      cfg_write_enable           cfg_index, cfg_data (no read-back)
//
// One tick per clock while the output is not stalled: a tick is held in the input register and
// its result then moves into the result register. The mode logic is one pass between those
// registers. Synchronous active-low reset returns the mode to idle and clears counters and
// latched gauge data. A stalled result holds, and the input register takes one more tick
// and then stalls the input until the result register frees up.
module battery_pack_power_mode_controller_core #(
  parameter int TICK_BITS = bpmc_pkg::TICK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_polarity_good,
  input  logic [15:0]        in_external_voltage,
  input  logic               in_pack_present,
  input  logic               in_button_on,
  input  logic               in_host_message_seen,
  input  logic               in_gauge_fresh,
  input  logic signed [15:0] in_gauge_current,
  input  logic               in_gauge_full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_mode,
  output logic               out_discharge_enable,
  output logic               out_charge_enable,
  output logic [2:0]         out_led_pattern,
  output logic [2:0]         out_beep_request,
  output logic               out_sleep_request,
  output logic               out_fault_recorded,
  input  logic               cfg_write_enable,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  bpmc_pkg::cfg_t       cfg_r;
  bpmc_pkg::item_t      item_r;
  logic                 s1_v_r;
  logic                 s1_v_nxt;
  bpmc_pkg::result_t    out_r;
  logic                 out_v_r;
  logic                 out_v_nxt;
  bpmc_pkg::ctl_state_t st_r;
  bpmc_pkg::ctl_state_t st_nxt;
  logic [TICK_BITS-1:0] mode_ticks_r;
  logic [TICK_BITS-1:0] mode_ticks_nxt;
  logic [TICK_BITS-1:0] gauge_age_r;
  logic [TICK_BITS-1:0] gauge_age_nxt;
  bpmc_pkg::result_t    res;
  logic                 s1_adv;
  logic                 in_xfer;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_timeout              <= bpmc_pkg::RST_DATA_TIMEOUT;
      cfg_r.idle_timeout              <= bpmc_pkg::RST_IDLE_TIMEOUT;
      cfg_r.lockout_time              <= bpmc_pkg::RST_LOCKOUT_TIME;
      cfg_r.charger_voltage_threshold <= bpmc_pkg::RST_CHARGER_VOLT;
      cfg_r.current_off_threshold     <= bpmc_pkg::RST_CURRENT_OFF;
      cfg_r.current_start_threshold   <= bpmc_pkg::RST_CURRENT_START;
      cfg_r.low_current_time          <= bpmc_pkg::RST_LOW_CURRENT_T;
      cfg_r.finish_time               <= bpmc_pkg::RST_FINISH_TIME;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        bpmc_pkg::REG_DATA_TIMEOUT:  cfg_r.data_timeout <= cfg_data;
        bpmc_pkg::REG_IDLE_TIMEOUT:  cfg_r.idle_timeout <= cfg_data;
        bpmc_pkg::REG_LOCKOUT_TIME:  cfg_r.lockout_time <= cfg_data;
        bpmc_pkg::REG_CHARGER_VOLT:  cfg_r.charger_voltage_threshold <= cfg_data[15:0];
        bpmc_pkg::REG_CURRENT_OFF:   cfg_r.current_off_threshold <= cfg_data[15:0];
        bpmc_pkg::REG_CURRENT_START: cfg_r.current_start_threshold <= cfg_data[15:0];
        bpmc_pkg::REG_LOW_CURRENT_T: cfg_r.low_current_time <= cfg_data;
        bpmc_pkg::REG_FINISH_TIME:   cfg_r.finish_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: the input register moves on whenever the result register frees up.
  assign s1_adv   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    out_v_nxt = s1_adv ? 1'b1 : ((out_v_r && !out_stall) ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Input register captures a tick on each transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.polarity_good     <= in_polarity_good;
      item_r.external_voltage  <= in_external_voltage;
      item_r.pack_present      <= in_pack_present;
      item_r.button_on         <= in_button_on;
      item_r.host_message_seen <= in_host_message_seen;
      item_r.gauge_fresh       <= in_gauge_fresh;
      item_r.gauge_current     <= in_gauge_current;
      item_r.gauge_full        <= in_gauge_full;
    end
  end

  bpmc_step #(
    .TICK_BITS(TICK_BITS)
  ) u_step (
    .item          (item_r),
    .cfg           (cfg_r),
    .st            (st_r),
    .mode_ticks    (mode_ticks_r),
    .gauge_age     (gauge_age_r),
    .st_nxt        (st_nxt),
    .mode_ticks_nxt(mode_ticks_nxt),
    .gauge_age_nxt (gauge_age_nxt),
    .res           (res)
  );

  // Controller state advances once per tick, as it moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode         <= bpmc_pkg::MODE_IDLE;
      st_r.held_current <= '0;
      st_r.held_full    <= 1'b0;
      st_r.fault_seen   <= 1'b0;
      mode_ticks_r      <= '0;
      gauge_age_r       <= '0;
    end else if (s1_adv) begin
      st_r         <= st_nxt;
      mode_ticks_r <= mode_ticks_nxt;
      gauge_age_r  <= gauge_age_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_adv) out_r <= res;
  end

  assign out_valid            = out_v_r;
  assign out_mode             = out_r.mode;
  assign out_discharge_enable = out_r.discharge_enable;
  assign out_charge_enable    = out_r.charge_enable;
  assign out_led_pattern      = out_r.led_pattern;
  assign out_beep_request     = out_r.beep_request;
  assign out_sleep_request    = out_r.sleep_request;
  assign out_fault_recorded   = out_r.fault_recorded;

`ifndef NO_ASSERTIONS
  // The input side only stalls while a tick waits in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with an empty input register");

  // A recorded fault stays recorded until reset.
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.fault_seen |=> st_r.fault_seen)
    else $error("fault record cleared without reset");

  // Discharge is enabled exactly in output mode.
  a_dsg_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_discharge_enable == (out_mode == 4'(bpmc_pkg::MODE_OUT))))
    else $error("discharge enable does not match the mode");

  // A sleep pulse comes only from idle, silently.
  a_sleep_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_sleep_request) |->
      (out_mode == 4'(bpmc_pkg::MODE_IDLE) && out_beep_request == 3'(bpmc_pkg::BEEP_NONE)))
    else $error("sleep request outside silent idle");
`endif

endmodule
